FILE: rtl/mexp_pkg.sv
// Shared constants, types and arithmetic helpers for the modular exponentiation block.
package mexp_pkg;

   localparam int MOD_WIDTH = 32;
   localparam int CNT_WIDTH = $clog2(MOD_WIDTH);

   localparam logic CSR_MODULUS  = 1'b0;
   localparam logic CSR_EXPONENT = 1'b1;

   localparam logic [MOD_WIDTH-1:0] MODULUS_RESET  = MOD_WIDTH'(21);
   localparam logic [MOD_WIDTH-1:0] EXPONENT_RESET = MOD_WIDTH'(5);

   typedef struct packed {
      logic load;      // capture a new word and start the reduction
      logic red_step;  // one bit of the input reduction
      logic mm_load;   // start a modular multiply
      logic sel_base;  // multiply by the base instead of squaring
      logic mm_dbl;    // double the partial product
      logic mm_add;    // conditionally add the multiplicand
      logic mm_end;    // move the product into the accumulator
      logic exp_shift; // advance to the next exponent bit
      logic finish;    // load the result register
   } mexp_cmd_type;

   typedef struct packed {
      logic mod_small; // modulus below two
      logic exp_msb;   // exponent bit being processed
   } mexp_status_type;

   // (x + y) mod m for x, y < m.
   function automatic logic [MOD_WIDTH-1:0] add_mod(input logic [MOD_WIDTH-1:0] x,
                                                    input logic [MOD_WIDTH-1:0] y,
                                                    input logic [MOD_WIDTH-1:0] m);
      logic [MOD_WIDTH:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[MOD_WIDTH-1:0];
   endfunction

endpackage

FILE: rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: controller plus datapath.
//
//   channel   ports                                        handshake
//   request   req_message_value                            start high while busy low
//   result    rsp_power_result                             rsp_valid, one cycle, no stall
//   config    csr_index, csr_write_data                    csr_write_enable
//
// A word is reduced below the modulus, then each exponent bit, top first, takes a
// squaring and, if set, a multiply by the base; a modulus below two goes straight to the result.
// The shift-and-add modular multiplier works one multiplier bit per double and add step.
// Reset is synchronous and active high; it restores modulus 21 and exponent 5.
// The result is shown for one cycle and the receiver cannot stall it.
module modular_exponentiation
   import mexp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [MOD_WIDTH-1:0] req_message_value,
   output logic                 rsp_valid,
   output logic [MOD_WIDTH-1:0] rsp_power_result,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [MOD_WIDTH-1:0] csr_write_data
);

   mexp_cmd_type    cmd;
   mexp_status_type status;

   mexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   mexp_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_message_value (req_message_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_power_result  (rsp_power_result)
   );

endmodule

FILE: rtl/mexp_ctrl.sv
// Sequencing state machine for the modular exponentiation block.
module mexp_ctrl
   import mexp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   output logic            rsp_valid,
   input  mexp_status_type status,
   output mexp_cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_REDUCE  = 7'b0000010,
      ST_MM_LOAD = 7'b0000100,
      ST_MM_DBL  = 7'b0001000,
      ST_MM_ADD  = 7'b0010000,
      ST_MM_END  = 7'b0100000,
      ST_FINISH  = 7'b1000000
   } state_type;

   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(MOD_WIDTH - 1);

   state_type            state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [CNT_WIDTH-1:0] ebit_ff, ebit_in;
   logic                 is_mul_ff, is_mul_in;
   logic                 valid_ff, valid_in;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ebit_in   = ebit_ff;
      is_mul_in = is_mul_ff;
      valid_in  = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load  = 1'b1;
               cnt_in    = '0;
               ebit_in   = '0;
               is_mul_in = 1'b0;
               state_in  = status.mod_small ? ST_FINISH : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.red_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_MM_LOAD;
            end
         end
         ST_MM_LOAD: begin
            cmd.mm_load  = 1'b1;
            cmd.sel_base = is_mul_ff;
            cnt_in       = '0;
            state_in     = ST_MM_DBL;
         end
         ST_MM_DBL: begin
            cmd.mm_dbl = 1'b1;
            state_in   = ST_MM_ADD;
         end
         ST_MM_ADD: begin
            cmd.mm_add = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            state_in   = (cnt_ff == CNT_LAST) ? ST_MM_END : ST_MM_DBL;
         end
         ST_MM_END: begin
            cmd.mm_end = 1'b1;
            // After squaring, a set exponent bit calls for one more multiply.
            if (!is_mul_ff && status.exp_msb) begin
               is_mul_in = 1'b1;
               state_in  = ST_MM_LOAD;
            end else begin
               cmd.exp_shift = 1'b1;
               is_mul_in     = 1'b0;
               ebit_in       = ebit_ff + 1'b1;
               state_in      = (ebit_ff == CNT_LAST) ? ST_FINISH : ST_MM_LOAD;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            valid_in   = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= 1'b0;
         cnt_ff    <= '0;
         ebit_ff   <= '0;
         is_mul_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         cnt_ff    <= cnt_in;
         ebit_ff   <= ebit_in;
         is_mul_ff <= is_mul_in;
      end
   end

`ifndef SYNTHESIS
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");

   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> (rsp_valid && !busy))
      else $error("finish did not produce a result");
`endif

endmodule

FILE: rtl/mexp_dp.sv
// Datapath of the modular exponentiation block: registers, reduction and modular add.
module mexp_dp
   import mexp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [MOD_WIDTH-1:0] csr_write_data,
   input  logic [MOD_WIDTH-1:0] req_message_value,
   input  mexp_cmd_type         cmd,
   output mexp_status_type      status,
   output logic [MOD_WIDTH-1:0] rsp_power_result
);

   logic [MOD_WIDTH-1:0] mod_ff, mod_in;
   logic [MOD_WIDTH-1:0] exp_ff, exp_in;
   logic [MOD_WIDTH-1:0] msg_ff, msg_in;
   logic [MOD_WIDTH-1:0] exps_ff, exps_in;
   logic [MOD_WIDTH-1:0] base_ff, base_in;
   logic [MOD_WIDTH-1:0] acc_ff, acc_in;
   logic [MOD_WIDTH-1:0] prod_ff, prod_in;
   logic [MOD_WIDTH-1:0] mult_ff, mult_in;
   logic [MOD_WIDTH-1:0] opa_ff, opa_in;
   logic [MOD_WIDTH-1:0] res_ff, res_in;
   logic [MOD_WIDTH:0]   red_sum;

   assign status.mod_small = (mod_ff < MOD_WIDTH'(2));
   assign status.exp_msb   = exps_ff[MOD_WIDTH-1];
   assign rsp_power_result = res_ff;

   // Remainder shifted by one input bit stays below twice the modulus.
   assign red_sum = {base_ff, msg_ff[MOD_WIDTH-1]};

   always_comb begin
      mod_in  = mod_ff;
      exp_in  = exp_ff;
      msg_in  = msg_ff;
      exps_in = exps_ff;
      base_in = base_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      mult_in = mult_ff;
      opa_in  = opa_ff;
      res_in  = res_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_MODULUS:  mod_in = csr_write_data;
            CSR_EXPONENT: exp_in = csr_write_data;
            default: ;
         endcase
      end

      if (cmd.load) begin
         msg_in  = req_message_value;
         exps_in = exp_ff;
         base_in = '0;
         acc_in  = status.mod_small ? '0 : MOD_WIDTH'(1);
      end
      if (cmd.red_step) begin
         msg_in = {msg_ff[MOD_WIDTH-2:0], 1'b0};
         if (red_sum >= {1'b0, mod_ff}) begin
            base_in = red_sum[MOD_WIDTH-1:0] - mod_ff;
         end else begin
            base_in = red_sum[MOD_WIDTH-1:0];
         end
      end
      if (cmd.mm_load) begin
         prod_in = '0;
         mult_in = acc_ff;
         opa_in  = cmd.sel_base ? base_ff : acc_ff;
      end
      if (cmd.mm_dbl) begin
         prod_in = add_mod(prod_ff, prod_ff, mod_ff);
      end
      if (cmd.mm_add) begin
         if (mult_ff[MOD_WIDTH-1]) begin
            prod_in = add_mod(prod_ff, opa_ff, mod_ff);
         end
         mult_in = {mult_ff[MOD_WIDTH-2:0], 1'b0};
      end
      if (cmd.mm_end) begin
         acc_in = prod_ff;
      end
      if (cmd.exp_shift) begin
         exps_in = {exps_ff[MOD_WIDTH-2:0], 1'b0};
      end
      if (cmd.finish) begin
         res_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MODULUS_RESET;
         exp_ff <= EXPONENT_RESET;
      end else begin
         mod_ff <= mod_in;
         exp_ff <= exp_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff  <= msg_in;
      exps_ff <= exps_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      mult_ff <= mult_in;
      opa_ff  <= opa_in;
      res_ff  <= res_in;
   end

`ifndef SYNTHESIS
   a_operands_reduced: assert property (@(posedge clock) disable iff (reset)
      cmd.mm_load |-> (acc_ff < mod_ff) && (base_ff < mod_ff))
      else $error("multiply operand not below the modulus");

   a_product_reduced: assert property (@(posedge clock) disable iff (reset)
      cmd.mm_dbl |-> (prod_ff < mod_ff) && (opa_ff < mod_ff))
      else $error("partial product not below the modulus");

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && !status.mod_small) |-> (acc_ff < mod_ff))
      else $error("result not below the modulus");
`endif

endmodule
